/* src/sle_pkg.sv */
// Shared types and constants for the sequential list engine.
package sle_pkg;

   // Default number of entries in the list.
   localparam int DEFAULT_LIST_DEPTH = 64;

   // Request mode codes.
   localparam logic [2:0] MODE_INSERT_AT  = 3'd0;
   localparam logic [2:0] MODE_ORDERED    = 3'd1;
   localparam logic [2:0] MODE_REMOVE_AT  = 3'd2;
   localparam logic [2:0] MODE_REMOVE_KEY = 3'd3;
   localparam logic [2:0] MODE_READ       = 3'd4;
   localparam logic [2:0] MODE_FIND       = 3'd5;

   // Request word.
   typedef struct packed {
      logic [2:0]         mode;
      logic [5:0]         position;
      logic signed [31:0] key_value;
   } req_type;

   // Response word.
   typedef struct packed {
      logic               ok;
      logic signed [31:0] read_value;
      logic [5:0]         found_position;
      logic [6:0]         element_count;
      logic               is_full;
      logic               is_empty;
   } rsp_type;

   // Index counter operations.
   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_COUNT,
      IDX_POS,
      IDX_ZERO,
      IDX_INC,
      IDX_DEC
   } idx_op_type;

   // Element count operations.
   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   // Store write data source.
   typedef enum logic {
      WD_KEY,
      WD_RDATA
   } wd_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load_req;
      logic       res_clear;
      idx_op_type idx_op;
      logic       rd_en;
      logic       rd_prev;
      logic       wr_en;
      logic       wr_prev;
      wd_sel_type wd_sel;
      cnt_op_type cnt_op;
      logic       set_ok;
      logic       cap_value;
      logic       cap_where;
      logic       rsp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [2:0] mode;
      logic       full;
      logic       pos_gt_count;
      logic       pos_ge_count;
      logic       idx_eq_pos;
      logic       idx_zero;
      logic       idx_lt_count;
      logic       key_match;
      logic       key_gt;
   } sts_type;

endpackage

/* src/sle_datapath.sv */
// Datapath of the list engine: entry store, count, index counter and response register.
module sle_datapath #(
   parameter int LIST_DEPTH = sle_pkg::DEFAULT_LIST_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  sle_pkg::req_type req_data,
   input  sle_pkg::cmd_type cmd,
   output sle_pkg::sts_type sts,
   output sle_pkg::rsp_type rsp_data
);

   localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam int EW = (CW > 7) ? CW : 7;

   // Entry store.
   logic signed [31:0] mem [LIST_DEPTH];
   logic signed [31:0] rd_data_ff;

   // Request registers.
   logic [2:0]         mode_ff;
   logic [5:0]         pos_ff;
   logic signed [31:0] key_ff;

   // Control registers.
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;

   // Result registers.
   logic               ok_ff;
   logic signed [31:0] value_ff;
   logic [5:0]         where_ff;
   sle_pkg::rsp_type   rsp_ff;

   logic [EW-1:0]      pos_ext, count_ext, idx_ext;
   logic [CW-1:0]      idx_m1;
   logic [IW-1:0]      rd_addr, wr_addr;
   logic signed [31:0] wr_data;
   logic               full;

   assign pos_ext   = {{(EW-6){1'b0}}, pos_ff};
   assign count_ext = EW'(count_ff);
   assign idx_ext   = EW'(idx_ff);
   assign idx_m1    = idx_ff - CW'(1);
   assign full      = (count_ff == CW'(LIST_DEPTH));

   // Status toward the controller.
   always_comb begin
      sts.mode         = mode_ff;
      sts.full         = full;
      sts.pos_gt_count = (pos_ext > count_ext);
      sts.pos_ge_count = (pos_ext >= count_ext);
      sts.idx_eq_pos   = (idx_ext == pos_ext);
      sts.idx_zero     = (idx_ff == '0);
      sts.idx_lt_count = (idx_ff < count_ff);
      sts.key_match    = (rd_data_ff == key_ff);
      sts.key_gt       = (key_ff > rd_data_ff);
   end

   // Store addressing: the index itself or the entry just below it.
   assign rd_addr = cmd.rd_prev ? idx_m1[IW-1:0] : idx_ff[IW-1:0];
   assign wr_addr = cmd.wr_prev ? idx_m1[IW-1:0] : idx_ff[IW-1:0];
   assign wr_data = (cmd.wd_sel == sle_pkg::WD_KEY) ? key_ff : rd_data_ff;

   // Store write port and registered read port.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Next index value.
   always_comb begin
      unique case (cmd.idx_op)
         sle_pkg::IDX_COUNT: idx_in = count_ff;
         sle_pkg::IDX_POS:   idx_in = pos_ext[CW-1:0];
         sle_pkg::IDX_ZERO:  idx_in = '0;
         sle_pkg::IDX_INC:   idx_in = idx_ff + CW'(1);
         sle_pkg::IDX_DEC:   idx_in = idx_m1;
         default:            idx_in = idx_ff;
      endcase
   end

   // Next element count.
   always_comb begin
      unique case (cmd.cnt_op)
         sle_pkg::CNT_INC: count_in = count_ff + CW'(1);
         sle_pkg::CNT_DEC: count_in = count_ff - CW'(1);
         default:          count_in = count_ff;
      endcase
   end

   // The count is the only register here with a reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Request, index and result registers.
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load_req) begin
         mode_ff <= req_data.mode;
         pos_ff  <= req_data.position;
         key_ff  <= req_data.key_value;
      end
      if (cmd.res_clear) begin
         ok_ff    <= 1'b0;
         value_ff <= '0;
         where_ff <= '0;
      end else begin
         if (cmd.set_ok) begin
            ok_ff <= 1'b1;
         end
         if (cmd.cap_value) begin
            value_ff <= rd_data_ff;
         end
         if (cmd.cap_where) begin
            where_ff <= idx_ext[5:0];
         end
      end
      if (cmd.rsp_load) begin
         rsp_ff.ok             <= ok_ff;
         rsp_ff.read_value     <= value_ff;
         rsp_ff.found_position <= where_ff;
         rsp_ff.element_count  <= count_ext[6:0];
         rsp_ff.is_full        <= full;
         rsp_ff.is_empty       <= (count_ff == '0);
      end
   end

   assign rsp_data = rsp_ff;

   // The count never goes past the depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(LIST_DEPTH))
      else $error("element count exceeds list depth");

   // Growing the list only happens when there is room.
   a_inc_not_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.cnt_op == sle_pkg::CNT_INC) |-> !full)
      else $error("count incremented while full");

   // Shrinking the list only happens when it holds something.
   a_dec_not_empty: assert property (@(posedge clock) disable iff (reset)
      (cmd.cnt_op == sle_pkg::CNT_DEC) |-> (count_ff != '0))
      else $error("count decremented while empty");

endmodule

/* src/sle_controller.sv */
// Controller state machine that sequences each list request over the datapath.
module sle_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  sle_pkg::sts_type sts,
   output sle_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_INS_CHK,
      ST_INS_WR,
      ST_ORD_CHK,
      ST_ORD_CMP,
      ST_POS_RD,
      ST_POS_CAP,
      ST_RM_CHK,
      ST_RM_WR,
      ST_SRCH_CHK,
      ST_SRCH_CMP,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Command decode and next state.
   always_comb begin
      cmd        = '0;
      cmd.idx_op = sle_pkg::IDX_HOLD;
      cmd.wd_sel = sle_pkg::WD_KEY;
      cmd.cnt_op = sle_pkg::CNT_HOLD;
      state_in   = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req  = 1'b1;
               cmd.res_clear = 1'b1;
               state_in      = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (sts.mode)
               sle_pkg::MODE_INSERT_AT: begin
                  if (sts.full || sts.pos_gt_count) begin
                     state_in = ST_FINISH;
                  end else begin
                     cmd.idx_op = sle_pkg::IDX_COUNT;
                     state_in   = ST_INS_CHK;
                  end
               end
               sle_pkg::MODE_ORDERED: begin
                  if (sts.full) begin
                     state_in = ST_FINISH;
                  end else begin
                     cmd.idx_op = sle_pkg::IDX_COUNT;
                     state_in   = ST_ORD_CHK;
                  end
               end
               sle_pkg::MODE_REMOVE_AT, sle_pkg::MODE_READ: begin
                  if (sts.pos_ge_count) begin
                     state_in = ST_FINISH;
                  end else begin
                     cmd.idx_op = sle_pkg::IDX_POS;
                     state_in   = ST_POS_RD;
                  end
               end
               sle_pkg::MODE_REMOVE_KEY, sle_pkg::MODE_FIND: begin
                  cmd.idx_op = sle_pkg::IDX_ZERO;
                  state_in   = ST_SRCH_CHK;
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         // Insert at a position: move entries up from the top until the slot is free.
         ST_INS_CHK: begin
            if (sts.idx_eq_pos) begin
               cmd.wr_en  = 1'b1;
               cmd.wd_sel = sle_pkg::WD_KEY;
               cmd.cnt_op = sle_pkg::CNT_INC;
               cmd.set_ok = 1'b1;
               state_in   = ST_FINISH;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_prev = 1'b1;
               state_in    = ST_INS_WR;
            end
         end
         ST_INS_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wd_sel = sle_pkg::WD_RDATA;
            cmd.idx_op = sle_pkg::IDX_DEC;
            state_in   = ST_INS_CHK;
         end
         // Ordered insert: move smaller keys up until the new key fits.
         ST_ORD_CHK: begin
            if (sts.idx_zero) begin
               cmd.wr_en  = 1'b1;
               cmd.wd_sel = sle_pkg::WD_KEY;
               cmd.cnt_op = sle_pkg::CNT_INC;
               cmd.set_ok = 1'b1;
               state_in   = ST_FINISH;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_prev = 1'b1;
               state_in    = ST_ORD_CMP;
            end
         end
         ST_ORD_CMP: begin
            cmd.wr_en = 1'b1;
            if (sts.key_gt) begin
               cmd.wd_sel = sle_pkg::WD_RDATA;
               cmd.idx_op = sle_pkg::IDX_DEC;
               state_in   = ST_ORD_CHK;
            end else begin
               cmd.wd_sel = sle_pkg::WD_KEY;
               cmd.cnt_op = sle_pkg::CNT_INC;
               cmd.set_ok = 1'b1;
               state_in   = ST_FINISH;
            end
         end
         // Read or remove at a position: fetch the entry first.
         ST_POS_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_POS_CAP;
         end
         ST_POS_CAP: begin
            cmd.cap_value = 1'b1;
            cmd.set_ok    = 1'b1;
            if (sts.mode == sle_pkg::MODE_REMOVE_AT) begin
               cmd.idx_op = sle_pkg::IDX_INC;
               state_in   = ST_RM_CHK;
            end else begin
               state_in = ST_FINISH;
            end
         end
         // Removal: move the entries above the gap down by one.
         ST_RM_CHK: begin
            if (sts.idx_lt_count) begin
               cmd.rd_en = 1'b1;
               state_in  = ST_RM_WR;
            end else begin
               cmd.cnt_op = sle_pkg::CNT_DEC;
               state_in   = ST_FINISH;
            end
         end
         ST_RM_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_prev = 1'b1;
            cmd.wd_sel  = sle_pkg::WD_RDATA;
            cmd.idx_op  = sle_pkg::IDX_INC;
            state_in    = ST_RM_CHK;
         end
         // Key search from the front of the list.
         ST_SRCH_CHK: begin
            if (sts.idx_lt_count) begin
               cmd.rd_en = 1'b1;
               state_in  = ST_SRCH_CMP;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SRCH_CMP: begin
            if (sts.key_match) begin
               cmd.set_ok = 1'b1;
               if (sts.mode == sle_pkg::MODE_FIND) begin
                  cmd.cap_where = 1'b1;
                  state_in      = ST_FINISH;
               end else begin
                  cmd.idx_op = sle_pkg::IDX_INC;
                  state_in   = ST_RM_CHK;
               end
            end else begin
               cmd.idx_op = sle_pkg::IDX_INC;
               state_in   = ST_SRCH_CHK;
            end
         end
         // Hand the result to the response register once it is free.
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response valid follows loads and handshakes.
   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // An accepted request always goes to dispatch next.
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DISPATCH))
      else $error("accepted request did not reach dispatch");

   // A result load never overwrites a word still waiting on the output.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten before it was taken");

   // The store is never read and written in the same cycle.
   a_port_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.rd_en && cmd.wr_en))
      else $error("store read and write issued together");

endmodule

/* src/sequential_list_engine_unit.sv */
// Each request passes from idle through dispatch; each entry moved or compared then takes a check
// state and a move or compare state, and the request ends in the finish state that loads the result.
// The store is never read and written in the same cycle, so each entry moved or compared
// takes two states. A new word is taken in the idle state after the previous result is loaded;
// a stalled output holds the block in the finish state. Reset is synchronous, empties the list
// by clearing the count and needs no clearing pass; the response register frees the input early.
// Top level of the sequential list engine.
module sequential_list_engine_unit #(
   parameter int LIST_DEPTH = sle_pkg::DEFAULT_LIST_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sle_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sle_pkg::rsp_type rsp_data
);

   sle_pkg::cmd_type cmd;
   sle_pkg::sts_type sts;

   // Sequencing of each request.
   sle_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Store, counters and result registers.
   sle_datapath #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

/* dv/tb_sequential_list_engine_unit.sv */
// Self-checking testbench for the sequential list engine: directed and random list requests.
`timescale 1ns / 1ps

module tb_sequential_list_engine_unit;

   localparam int DEPTH            = sle_pkg::DEFAULT_LIST_DEPTH;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES      = 200;

   // Mode codes that the block does not implement.
   localparam logic [2:0] MODE_SPARE_A = 3'd6;
   localparam logic [2:0] MODE_SPARE_B = 3'd7;

   localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   sle_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   sle_pkg::rsp_type rsp_data;

   // Shadow copy of the list contents and the occupied count.
   logic signed [31:0] shadow_entries [DEPTH];
   int                 shadow_count;

   sle_pkg::rsp_type expected_rsp_q[$];

   bit idle_enable;
   int hold_rsp_requests = 0;
   int error_count       = 0;
   int words_sent;
   int results_checked   = 0;
   int failed_requests   = 0;
   int full_responses    = 0;

   sequential_list_engine_unit #(
      .LIST_DEPTH(DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #(5_000_000);
      $display("tb_sequential_list_engine_unit: errors");
      $finish;
   end

   // Returns the index of the first entry equal to the key, or -1.
   function automatic int first_key_index(input logic signed [31:0] key);
      int i;
      for (i = 0; i < shadow_count; i++) begin
         if (shadow_entries[i] == key) return i;
      end
      return -1;
   endfunction

   // Removes one entry and closes the gap.
   function automatic void drop_entry(input int idx);
      int i;
      for (i = idx + 1; i < shadow_count; i++) shadow_entries[i - 1] = shadow_entries[i];
      shadow_count--;
   endfunction

   // Applies one request to the shadow list and returns the response it should give.
   function automatic sle_pkg::rsp_type predict_list_op(input sle_pkg::req_type w);
      sle_pkg::rsp_type   r;
      logic signed [31:0] key;
      int                 pos;
      int                 i;
      r   = '0;
      key = w.key_value;
      pos = int'(w.position);
      case (w.mode)
         sle_pkg::MODE_INSERT_AT: begin
            if (shadow_count < DEPTH && pos <= shadow_count) begin
               for (i = shadow_count; i > pos; i--) shadow_entries[i] = shadow_entries[i - 1];
               shadow_entries[pos] = key;
               shadow_count++;
               r.ok = 1'b1;
            end
         end
         sle_pkg::MODE_ORDERED: begin
            // Descending order; a new key lands after keys equal to it.
            if (shadow_count < DEPTH) begin
               i = shadow_count;
               while (i > 0 && key > shadow_entries[i - 1]) begin
                  shadow_entries[i] = shadow_entries[i - 1];
                  i--;
               end
               shadow_entries[i] = key;
               shadow_count++;
               r.ok = 1'b1;
            end
         end
         sle_pkg::MODE_REMOVE_AT: begin
            if (pos < shadow_count) begin
               r.read_value = shadow_entries[pos];
               r.ok         = 1'b1;
               drop_entry(pos);
            end
         end
         sle_pkg::MODE_REMOVE_KEY: begin
            i = first_key_index(key);
            if (i >= 0) begin
               drop_entry(i);
               r.ok = 1'b1;
            end
         end
         sle_pkg::MODE_READ: begin
            if (pos < shadow_count) begin
               r.read_value = shadow_entries[pos];
               r.ok         = 1'b1;
            end
         end
         sle_pkg::MODE_FIND: begin
            i = first_key_index(key);
            if (i >= 0) begin
               r.found_position = 6'(i);
               r.ok             = 1'b1;
            end
         end
         default: begin
         end
      endcase
      r.element_count = 7'(shadow_count);
      r.is_full       = (shadow_count == DEPTH);
      r.is_empty      = (shadow_count == 0);
      return r;
   endfunction

   function automatic sle_pkg::req_type list_word(input logic [2:0] mode,
                                                  input logic [5:0] pos,
                                                  input logic signed [31:0] key);
      sle_pkg::req_type w;
      w.mode      = mode;
      w.position  = pos;
      w.key_value = key;
      return w;
   endfunction

   // Picks a key: often one already in the list, else a small value or a full random word.
   function automatic logic signed [31:0] pick_key(input int reuse_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (shadow_count > 0 && roll < reuse_pct) begin
         return shadow_entries[$urandom_range(0, shadow_count - 1)];
      end
      if ($urandom_range(0, 1) == 1) return int'($urandom_range(0, 16)) - 8;
      return $urandom();
   endfunction

   // Builds a mostly well-formed request; grow_pct steers how fast the list fills.
   function automatic sle_pkg::req_type make_list_word(input int grow_pct, input int noise_pct);
      sle_pkg::req_type w;
      int               roll;
      if ($urandom_range(0, 99) < noise_pct) begin
         w.mode      = 3'($urandom_range(0, 7));
         w.position  = 6'($urandom_range(0, 63));
         w.key_value = $urandom();
         return w;
      end
      roll = $urandom_range(0, 99);
      if (roll < grow_pct / 2) begin
         w.mode = sle_pkg::MODE_INSERT_AT;
      end else if (roll < grow_pct) begin
         w.mode = sle_pkg::MODE_ORDERED;
      end else begin
         case ($urandom_range(0, 3))
            0: w.mode = sle_pkg::MODE_REMOVE_AT;
            1: w.mode = sle_pkg::MODE_REMOVE_KEY;
            2: w.mode = sle_pkg::MODE_READ;
            default: w.mode = sle_pkg::MODE_FIND;
         endcase
      end
      w.key_value = pick_key((w.mode == sle_pkg::MODE_REMOVE_KEY ||
                              w.mode == sle_pkg::MODE_FIND) ? 80 : 25);
      if (w.mode == sle_pkg::MODE_INSERT_AT && shadow_count < DEPTH) begin
         w.position = 6'($urandom_range(0, shadow_count));
      end else if (w.mode != sle_pkg::MODE_INSERT_AT && shadow_count > 0) begin
         w.position = 6'($urandom_range(0, shadow_count - 1));
      end else begin
         w.position = 6'($urandom_range(0, 63));
      end
      return w;
   endfunction

   // Offers one word, waits for the handshake and records the expected response.
   // Valid is left high on return so back-to-back words need no second assignment.
   task automatic send_list_word(input sle_pkg::req_type w);
      int gap;
      gap = 0;
      if (idle_enable && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      expected_rsp_q.push_back(predict_list_op(w));
      words_sent++;
   endtask

   // Stops offering words until every expected response has come back.
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_rsp_q.size() != 0);
   endtask

   // Empty-list failures, spare modes, inserts at both ends, ties and misses.
   task automatic test_directed_cases();
      send_list_word(list_word(sle_pkg::MODE_READ, 6'd0, 32'sd0));
      send_list_word(list_word(sle_pkg::MODE_REMOVE_AT, 6'd0, 32'sd0));
      send_list_word(list_word(sle_pkg::MODE_REMOVE_KEY, 6'd0, 32'sd5));
      send_list_word(list_word(sle_pkg::MODE_FIND, 6'd0, 32'sd5));
      send_list_word(list_word(MODE_SPARE_A, 6'd63, -32'sd1));
      send_list_word(list_word(MODE_SPARE_B, 6'd0, KEY_MIN));
      send_list_word(list_word(sle_pkg::MODE_INSERT_AT, 6'd1, 32'sd9));
      send_list_word(list_word(sle_pkg::MODE_INSERT_AT, 6'd0, KEY_MAX));
      send_list_word(list_word(sle_pkg::MODE_INSERT_AT, 6'd1, KEY_MIN));
      send_list_word(list_word(sle_pkg::MODE_INSERT_AT, 6'd1, 32'sd0));
      send_list_word(list_word(sle_pkg::MODE_READ, 6'd0, 32'sd0));
      send_list_word(list_word(sle_pkg::MODE_READ, 6'd2, 32'sd0));
      send_list_word(list_word(sle_pkg::MODE_READ, 6'd3, 32'sd0));
      send_list_word(list_word(sle_pkg::MODE_ORDERED, 6'd0, 32'sd0));
      send_list_word(list_word(sle_pkg::MODE_ORDERED, 6'd63, -32'sd1));
      send_list_word(list_word(sle_pkg::MODE_ORDERED, 6'd0, KEY_MAX));
      send_list_word(list_word(sle_pkg::MODE_ORDERED, 6'd0, KEY_MIN));
      send_list_word(list_word(sle_pkg::MODE_FIND, 6'd0, 32'sd0));
      send_list_word(list_word(sle_pkg::MODE_FIND, 6'd0, 32'sd12345));
      send_list_word(list_word(sle_pkg::MODE_REMOVE_KEY, 6'd0, 32'sd0));
      send_list_word(list_word(sle_pkg::MODE_REMOVE_KEY, 6'd0, 32'sd777));
      send_list_word(list_word(sle_pkg::MODE_REMOVE_AT, 6'd0, 32'sd0));
      send_list_word(list_word(sle_pkg::MODE_REMOVE_AT, 6'd63, 32'sd0));
      send_list_word(list_word(MODE_SPARE_A, 6'd1, KEY_MAX));
      send_list_word(list_word(sle_pkg::MODE_READ, 6'd63, 32'sd0));
   endtask

   // Fills the list to its depth, probes the full list and the last entry, then empties it.
   task automatic test_full_list();
      while (shadow_count < DEPTH) begin
         if ($urandom_range(0, 1) == 1) begin
            send_list_word(list_word(sle_pkg::MODE_INSERT_AT,
                                     6'($urandom_range(0, shadow_count)), $urandom()));
         end else begin
            send_list_word(list_word(sle_pkg::MODE_ORDERED, 6'($urandom_range(0, 63)),
                                     $urandom()));
         end
      end
      send_list_word(list_word(sle_pkg::MODE_INSERT_AT, 6'd0, 32'sd1));
      send_list_word(list_word(sle_pkg::MODE_ORDERED, 6'd0, 32'sd1));
      send_list_word(list_word(sle_pkg::MODE_READ, 6'd63, 32'sd0));
      send_list_word(list_word(sle_pkg::MODE_FIND, 6'd0, shadow_entries[DEPTH - 1]));
      send_list_word(list_word(sle_pkg::MODE_REMOVE_AT, 6'd63, 32'sd0));
      send_list_word(list_word(sle_pkg::MODE_INSERT_AT, 6'd63, KEY_MIN));
      send_list_word(list_word(sle_pkg::MODE_REMOVE_KEY, 6'd0, shadow_entries[10]));
      while (shadow_count > 0) begin
         send_list_word(list_word(sle_pkg::MODE_REMOVE_AT,
                                  6'($urandom_range(0, shadow_count - 1)), 32'sd0));
      end
   endtask

   // Phases of random traffic, each with its own fill tendency and idling choice.
   task automatic test_random_traffic(input int phases);
      int phase;
      int n;
      int grow_pct;
      for (phase = 0; phase < phases; phase++) begin
         grow_pct    = $urandom_range(15, 80);
         idle_enable = ($urandom_range(0, 3) != 0);
         for (n = 0; n < 100; n++) send_list_word(make_list_word(grow_pct, 15));
      end
      idle_enable = 1'b1;
   endtask

   // The receiver holds off for a long stretch while words keep coming.
   task automatic test_response_backpressure();
      int n;
      hold_rsp_requests++;
      for (n = 0; n < 12; n++) send_list_word(make_list_word(50, 0));
   endtask

   // The sender stops until every response is back, then resumes.
   task automatic test_sender_pause();
      int n;
      for (n = 0; n < 20; n++) send_list_word(make_list_word(50, 10));
      pause_until_drained();
      for (n = 0; n < 20; n++) send_list_word(make_list_word(50, 10));
   endtask

   // Builds a sorted list from scratch with many equal keys, then searches and trims it.
   task automatic test_ordered_list();
      int n;
      while (shadow_count > 0) begin
         send_list_word(list_word(sle_pkg::MODE_REMOVE_AT,
                                  6'($urandom_range(0, shadow_count - 1)), 32'sd0));
      end
      for (n = 0; n < 60; n++) begin
         if ($urandom_range(0, 3) == 0) begin
            send_list_word(list_word(sle_pkg::MODE_ORDERED, 6'd0, $urandom()));
         end else begin
            send_list_word(list_word(sle_pkg::MODE_ORDERED, 6'd0,
                                     int'($urandom_range(0, 8)) - 4));
         end
      end
      for (n = 0; n < 60; n++) begin
         case ($urandom_range(0, 2))
            0: send_list_word(list_word(sle_pkg::MODE_FIND, 6'd0, pick_key(70)));
            1: send_list_word(list_word(sle_pkg::MODE_READ,
                                        6'($urandom_range(0, shadow_count)), 32'sd0));
            default: send_list_word(list_word(sle_pkg::MODE_REMOVE_KEY, 6'd0, pick_key(70)));
         endcase
      end
   endtask

   // Final stretch with no idling on either side.
   task automatic test_streaming_no_idle();
      int n;
      idle_enable = 1'b0;
      for (n = 0; n < 150; n++) send_list_word(make_list_word(45, 10));
   endtask

   // Response side: random stalls, plus one long hold each time one is asked for.
   initial begin : rsp_drive
      int stall_len;
      int holds_served;
      rsp_ready    = 1'b0;
      holds_served = 0;
      forever begin
         @(posedge clock);
         stall_len = 0;
         if (hold_rsp_requests > holds_served) begin
            holds_served++;
            stall_len = LONG_HOLD_CYCLES;
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            stall_len = $urandom_range(1, 10);
         end
         if (stall_len > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall_len) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Response checker: signals are stable at the falling edge, and a word seen
   // there with valid and ready high is taken at the next rising edge.
   initial begin : rsp_check
      sle_pkg::rsp_type want;
      sle_pkg::rsp_type got;
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (expected_rsp_q.size() == 0) begin
               $error("response word %h arrived with none expected", got);
               error_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               results_checked++;
               if (!want.ok) failed_requests++;
               if (want.is_full) full_responses++;
               if (got.ok !== want.ok) begin
                  $error("ok: expected %0d, got %0d", want.ok, got.ok);
                  error_count++;
               end
               if (got.read_value !== want.read_value) begin
                  $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
                  error_count++;
               end
               if (got.found_position !== want.found_position) begin
                  $error("found_position: expected %0d, got %0d",
                         want.found_position, got.found_position);
                  error_count++;
               end
               if (got.element_count !== want.element_count) begin
                  $error("element_count: expected %0d, got %0d",
                         want.element_count, got.element_count);
                  error_count++;
               end
               if (got.is_full !== want.is_full) begin
                  $error("is_full: expected %0d, got %0d", want.is_full, got.is_full);
                  error_count++;
               end
               if (got.is_empty !== want.is_empty) begin
                  $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
                  error_count++;
               end
            end
         end
      end
   end

   // Main sequence.
   initial begin : main_flow
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      idle_enable  = 1'b1;
      shadow_count = 0;
      words_sent   = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_full_list();
      test_random_traffic(6);
      test_response_backpressure();
      test_sender_pause();
      test_ordered_list();
      test_random_traffic(7);
      test_streaming_no_idle();

      pause_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d request words and checked %0d responses (%0d failed requests).",
               words_sent, results_checked, failed_requests);
      $display("All modes, spare codes, empty and full lists (%0d full responses), ties, %s",
               full_responses, "stalls on both sides and one long response hold.");
      if (error_count == 0) begin
         $display("tb_sequential_list_engine_unit: clean");
      end else begin
         $display("tb_sequential_list_engine_unit: errors");
      end
      $finish;
   end

endmodule

/* sim.f */
src/sle_pkg.sv
src/sle_datapath.sv
src/sle_controller.sv
src/sequential_list_engine_unit.sv
dv/tb_sequential_list_engine_unit.sv
